FILE: src/dpm_pkg.sv
// ----------------------------------------------------------------------------
// dpm_pkg
// Shared constants and types for the demand-paging memory block.
// ----------------------------------------------------------------------------
package dpm_pkg;

  localparam int OFFSET_BITS = 12;
  localparam int NUM_FRAMES  = 64;
  localparam int VADDR_BITS  = 32;

  localparam int FRAME_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_BITS   = $clog2(NUM_FRAMES + 1);
  localparam int VPN_BITS   = VADDR_BITS - OFFSET_BITS;
  localparam int PHYS_BITS  = 18;
  localparam int PADDR_BITS = FRAME_BITS + OFFSET_BITS;
  localparam int LANES      = 4;
  localparam int LANE_BITS  = 2;
  localparam int ROW_BITS   = PADDR_BITS - LANE_BITS;
  localparam int ROWS       = 1 << ROW_BITS;

  // access kinds
  localparam logic [2:0] KIND_RD8  = 3'd0;
  localparam logic [2:0] KIND_RD16 = 3'd1;
  localparam logic [2:0] KIND_RD32 = 3'd2;
  localparam logic [2:0] KIND_WR8  = 3'd3;
  localparam logic [2:0] KIND_WR16 = 3'd4;
  localparam logic [2:0] KIND_WR32 = 3'd5;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                               hit;
    logic                               full;
    logic [FRAME_BITS-1:0]              frame;
  } ptab_res_t;

  typedef struct packed {
    logic [LANES-1:0]                   we;
    logic [LANES-1:0]                   re;
    logic [LANES-1:0][ROW_BITS-1:0]     row;
    logic [LANES-1:0][7:0]              wdata;
  } mem_req_t;

endpackage

FILE: src/demand_paging_mmu_memory.sv
// ----------------------------------------------------------------------------
// demand_paging_mmu_memory
// Translates byte/halfword/word accesses through a demand-filled page table
// and performs them on a flat little-endian physical memory.
// ----------------------------------------------------------------------------
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  in      | in_valid, in_ready, kind, vaddr, write_data     | in
//  out     | out_valid, out_ready, read_data, phys_addr,     | out
//          | page_fault, out_of_frames                       |
//
//  an item goes through lookup plus memory access, then read-data assembly
//  the memory port has a registered read, which puts assembly in a later state
//  after reset a clearing pass zeroes memory, one row of 4 bytes per cycle,
//  covering all 65536 rows with in_ready low
//  a finished item waits in the output register; the next item is taken
//  meanwhile and holds in its last cycle until that register frees up
// ----------------------------------------------------------------------------
module demand_paging_mmu_memory (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     kind,
  input  logic [31:0]                    vaddr,
  input  logic [31:0]                    write_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    read_data,
  output logic [dpm_pkg::PHYS_BITS-1:0]  phys_addr,
  output logic                           page_fault,
  output logic                           out_of_frames
);

  dpm_pkg::state_t   state, state_next;
  dpm_pkg::ptab_res_t pt_res;
  dpm_pkg::mem_req_t  mreq;

  logic [dpm_pkg::ROW_BITS-1:0]   clr_row;
  logic [2:0]                     kind_q;
  logic [31:0]                    vaddr_q;
  logic [31:0]                    wdata_q;

  logic [dpm_pkg::LANES-1:0][7:0] mem_rdata;
  logic [dpm_pkg::PADDR_BITS-1:0] pa;
  logic [dpm_pkg::VPN_BITS-1:0]   vpn;
  logic [2:0]                     nbytes;
  logic                           kind_ok;
  logic                           is_wr;
  logic                           go;
  logic                           claim;
  logic                           oof;
  logic                           out_free;
  logic                           accept;

  // per-item results carried into the response cycle
  logic [dpm_pkg::PADDR_BITS-1:0] r_pa;
  logic                           r_fault;
  logic                           r_oof;
  logic                           r_read;
  logic [2:0]                     r_nbytes;
  logic [31:0]                    rd_word;

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign vpn      = vaddr_q[dpm_pkg::VADDR_BITS-1:dpm_pkg::OFFSET_BITS];

  dpm_ptab u_ptab (
    .clk   (clk),
    .rst   (rst),
    .vpn   (vpn),
    .claim (claim),
    .res   (pt_res)
  );

  dpm_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpm_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      dpm_pkg::S_CLEAR: begin
        if (&clr_row) begin
          state_next = dpm_pkg::S_IDLE;
        end
      end
      dpm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = dpm_pkg::S_LOOK;
        end
      end
      dpm_pkg::S_LOOK: begin
        state_next = dpm_pkg::S_RESP;
      end
      dpm_pkg::S_RESP: begin
        in_ready = out_free;
        if (out_free) begin
          state_next = in_valid ? dpm_pkg::S_LOOK : dpm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dpm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (state == dpm_pkg::S_CLEAR) begin
      clr_row <= clr_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= kind;
      vaddr_q <= vaddr;
      wdata_q <= write_data;
    end
  end

  // decode and translate
  always_comb begin
    kind_ok = (kind_q <= dpm_pkg::KIND_WR32);
    is_wr   = (kind_q >= dpm_pkg::KIND_WR8);
    case (kind_q)
      dpm_pkg::KIND_RD8,  dpm_pkg::KIND_WR8:  nbytes = 3'd1;
      dpm_pkg::KIND_RD16, dpm_pkg::KIND_WR16: nbytes = 3'd2;
      dpm_pkg::KIND_RD32, dpm_pkg::KIND_WR32: nbytes = 3'd4;
      default:                                nbytes = 3'd0;
    endcase
    go    = (state == dpm_pkg::S_LOOK) && kind_ok && (pt_res.hit || !pt_res.full);
    claim = go && !pt_res.hit;
    oof   = (state == dpm_pkg::S_LOOK) && kind_ok && !pt_res.hit && pt_res.full;
    pa    = {pt_res.frame, vaddr_q[dpm_pkg::OFFSET_BITS-1:0]};
  end

  // lane b holds byte (b - pa) mod 4; lanes below the start offset use the next row
  always_comb begin
    logic [dpm_pkg::LANE_BITS-1:0] lane_i;
    logic [dpm_pkg::LANE_BITS-1:0] pa_lo;
    logic [dpm_pkg::ROW_BITS-1:0]  pa_row;
    pa_lo  = pa[dpm_pkg::LANE_BITS-1:0];
    pa_row = pa[dpm_pkg::PADDR_BITS-1:dpm_pkg::LANE_BITS];
    for (int b = 0; b < dpm_pkg::LANES; b++) begin
      lane_i = dpm_pkg::LANE_BITS'(b) - pa_lo;
      if (state == dpm_pkg::S_CLEAR) begin
        mreq.we[b]    = 1'b1;
        mreq.re[b]    = 1'b0;
        mreq.row[b]   = clr_row;
        mreq.wdata[b] = 8'h00;
      end else begin
        mreq.we[b]    = go && is_wr && ({1'b0, lane_i} < nbytes);
        mreq.re[b]    = go && !is_wr;
        mreq.row[b]   = pa_row + dpm_pkg::ROW_BITS'(dpm_pkg::LANE_BITS'(b) < pa_lo);
        mreq.wdata[b] = wdata_q[8*lane_i +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == dpm_pkg::S_LOOK) begin
      r_pa     <= go ? pa : '0;
      r_fault  <= claim;
      r_oof    <= oof;
      r_read   <= go && !is_wr;
      r_nbytes <= nbytes;
    end
  end

  // reassemble little-endian bytes from the lanes
  always_comb begin
    logic [dpm_pkg::LANE_BITS-1:0] lane_b;
    for (int i = 0; i < dpm_pkg::LANES; i++) begin
      lane_b = r_pa[dpm_pkg::LANE_BITS-1:0] + dpm_pkg::LANE_BITS'(i);
      if (r_read && (3'(i) < r_nbytes)) begin
        rd_word[8*i +: 8] = mem_rdata[lane_b];
      end else begin
        rd_word[8*i +: 8] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == dpm_pkg::S_RESP) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == dpm_pkg::S_RESP) && out_free) begin
      read_data     <= rd_word;
      phys_addr     <= dpm_pkg::PHYS_BITS'(r_pa);
      page_fault    <= r_fault;
      out_of_frames <= r_oof;
    end
  end

endmodule

FILE: src/dpm_ptab.sv
// ----------------------------------------------------------------------------
// dpm_ptab
// Page table: one page number per claimed frame, searched in parallel.
// ----------------------------------------------------------------------------
module dpm_ptab (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dpm_pkg::VPN_BITS-1:0] vpn,
  input  logic                         claim,
  output dpm_pkg::ptab_res_t           res
);

  logic [dpm_pkg::VPN_BITS-1:0]   tbl [dpm_pkg::NUM_FRAMES];
  logic [dpm_pkg::CNT_BITS-1:0]   used;
  logic [dpm_pkg::FRAME_BITS-1:0] hit_frame;
  logic                           hit_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (claim) begin
      used <= used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      tbl[used[dpm_pkg::FRAME_BITS-1:0]] <= vpn;
    end
  end

  // only slots below the fill count hold a page number
  always_comb begin
    hit_frame = '0;
    hit_any   = 1'b0;
    for (int i = 0; i < dpm_pkg::NUM_FRAMES; i++) begin
      if ((dpm_pkg::CNT_BITS'(i) < used) && (tbl[i] == vpn)) begin
        hit_any   = 1'b1;
        hit_frame = hit_frame | dpm_pkg::FRAME_BITS'(i);
      end
    end
    res.hit   = hit_any;
    res.full  = (used == dpm_pkg::CNT_BITS'(dpm_pkg::NUM_FRAMES));
    res.frame = hit_any ? hit_frame : used[dpm_pkg::FRAME_BITS-1:0];
  end

endmodule

FILE: src/dpm_store.sv
// ----------------------------------------------------------------------------
// dpm_store
// Physical memory as four byte lanes, each with its own row address.
// ----------------------------------------------------------------------------
module dpm_store (
  input  logic                            clk,
  input  dpm_pkg::mem_req_t               req,
  output logic [dpm_pkg::LANES-1:0][7:0]  rdata
);

  for (genvar b = 0; b < dpm_pkg::LANES; b++) begin : g_lane
    logic [7:0] mem [dpm_pkg::ROWS];

    always_ff @(posedge clk) begin
      if (req.we[b]) begin
        mem[req.row[b]] <= req.wdata[b];
      end
      if (req.re[b]) begin
        rdata[b] <= mem[req.row[b]];
      end
    end
  end

endmodule
